FILE: rtl/tsgh_pkg.sv
`default_nettype none

package tsgh_pkg;

   // fixed field widths of the item channels
   localparam int OP_W        = 2;
   localparam int TS_W        = 32;
   localparam int GROUP_W     = 3;
   localparam int COUNT_OUT_W = 32;
   localparam int AG_W        = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // number of stored thresholds (upper bounds of groups 0..6)
   localparam int NUM_THRESHOLDS = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_GROUPS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_1   = 3'd1;

   // item operations
   typedef enum logic [OP_W-1:0] {
      OP_CLASSIFY = 2'd0,
      OP_READ     = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

endpackage

`default_nettype wire

FILE: rtl/time_step_group_histogram.sv
// time_step_group_histogram
//
// Bins element time steps (unsigned Q8.24) into up to MAX_GROUPS groups by
// ascending thresholds and keeps a saturating counter per group.
// Input channel req_*: op, time_step, group_index. Result channel rsp_*:
// group, count. Both use valid/stall; an item moves when valid is high and
// stall is low. Every input item gives exactly one result item.
// Configuration: csr_wr_en with csr_index/csr_wr_data writes active_groups
// (index 0) or threshold_1..threshold_7 (index 1..7); write only while idle.
// Each accepted item passes the input stage, then the result register.
// Throughput: one item per cycle while the result channel does not stall,
// with the counter read, increment and write-back in the second stage.
// Stall: when rsp_stall holds a waiting result, an empty input stage still
// takes one more item; after that req_stall rises until the result is taken.
// Reset: counters cleared, active_groups = 1, thresholds all ones, both
// stages empty. A clear item zeroes all counters together.

`default_nettype none

module time_step_group_histogram
   import tsgh_pkg::*;
#(
   parameter int MAX_GROUPS = 8,
   parameter int COUNT_BITS = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   // input channel
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire [OP_W-1:0]         req_op,
   input  wire [TS_W-1:0]         req_time_step,
   input  wire [GROUP_W-1:0]      req_group_index,
   // result channel
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [GROUP_W-1:0]     rsp_group,
   output logic [COUNT_OUT_W-1:0] rsp_count,
   // configuration port
   input  wire                    csr_wr_en,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wr_data
);

   localparam int CIDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

   // configuration registers
   logic [AG_W-1:0]  active_groups_ff;
   logic [TS_W-1:0]  thr_ff [NUM_THRESHOLDS];
   logic [CSR_IDX_W-1:0] thr_idx;

   // input stage
   logic                      s1_valid_ff, s1_valid_in;
   op_type                    s1_op_ff;
   logic [GROUP_W-1:0]        s1_gi_ff;
   logic [NUM_THRESHOLDS-1:0] s1_lt_ff, s1_lt_in;

   // counters and result register
   logic [COUNT_BITS-1:0]  counts_ff [MAX_GROUPS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GROUP_W-1:0]     rsp_group_ff, rsp_group_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic out_free, s1_fire, req_fire;
   logic [AG_W-1:0]       n_use;
   logic [CIDX_W-1:0]     cls_grp, sel;
   logic                  gi_in_range;
   logic [COUNT_BITS-1:0] cur, inc, rep_src;
   logic [63:0]           rep_wide;
   logic [COUNT_OUT_W-1:0] rep;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   // threshold compares on the incoming time step
   always_comb begin
      for (int i = 0; i < NUM_THRESHOLDS; i++) begin
         s1_lt_in[i] = req_time_step < thr_ff[i];
      end
   end

   // groups in use, clamped to 1..MAX_GROUPS
   always_comb begin
      n_use = active_groups_ff;
      if (active_groups_ff == '0) begin
         n_use = AG_W'(1);
      end else if (int'(active_groups_ff) > MAX_GROUPS) begin
         n_use = AG_W'(MAX_GROUPS);
      end
   end

   // first group whose upper bound exceeds the time step
   always_comb begin
      cls_grp = CIDX_W'(n_use - AG_W'(1));
      for (int g = MAX_GROUPS - 2; g >= 0; g--) begin
         if (((g + 1) < int'(n_use)) && s1_lt_ff[g]) begin
            cls_grp = CIDX_W'(g);
         end
      end
   end

   // counter read, saturating increment and 32-bit report
   assign gi_in_range = int'(s1_gi_ff) < MAX_GROUPS;
   assign sel     = (s1_op_ff == OP_CLASSIFY) ? cls_grp : s1_gi_ff[CIDX_W-1:0];
   assign cur     = counts_ff[sel];
   assign inc     = (cur == '1) ? cur : cur + COUNT_BITS'(1);
   assign rep_src = (s1_op_ff == OP_CLASSIFY) ? inc : cur;
   assign rep_wide = 64'(rep_src);
   assign rep     = (|rep_wide[63:32]) ? '1 : rep_wide[31:0];

   // result payload
   always_comb begin
      rsp_group_in = '0;
      rsp_count_in = '0;
      case (s1_op_ff)
         OP_CLASSIFY: begin
            rsp_group_in = GROUP_W'(cls_grp);
            rsp_count_in = rep;
         end
         OP_READ: begin
            rsp_group_in = s1_gi_ff;
            rsp_count_in = gi_in_range ? rep : '0;
         end
         default: begin
            rsp_group_in = '0;
            rsp_count_in = '0;
         end
      endcase
   end

   assign thr_idx = csr_index - CSR_THRESHOLD_1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_groups_ff <= AG_W'(1);
         for (int i = 0; i < NUM_THRESHOLDS; i++) begin
            thr_ff[i] <= '1;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_GROUPS: active_groups_ff <= csr_wr_data[AG_W-1:0];
            default: thr_ff[thr_idx] <= csr_wr_data[TS_W-1:0];
         endcase
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff <= op_type'(req_op);
         s1_gi_ff <= req_group_index;
         s1_lt_ff <= s1_lt_in;
      end
   end

   // pipeline control and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire) begin
         rsp_group_ff <= rsp_group_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   // group counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_GROUPS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         case (s1_op_ff)
            OP_CLASSIFY: counts_ff[cls_grp] <= inc;
            OP_CLEAR: begin
               for (int i = 0; i < MAX_GROUPS; i++) begin
                  counts_ff[i] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_group = rsp_group_ff;
   assign rsp_count = rsp_count_ff;

   // a clear item reports group 0 and count 0
   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_op_ff == OP_CLEAR) |=> (rsp_group == '0 && rsp_count == '0))
      else $error("clear item gave a nonzero result");

   // a classify item always sees a count of at least one
   a_classify_nonzero: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_op_ff == OP_CLASSIFY) |=> (rsp_count != '0))
      else $error("classify item returned a zero count");

   // a classified group stays inside the groups in use
   a_classify_range: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_op_ff == OP_CLASSIFY) |=> (AG_W'(rsp_group) < $past(n_use)))
      else $error("classify group beyond groups in use");

   // the input side stalls only with a full input stage and a held result
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tsgh_pkg::*;

   localparam int MAX_GROUPS = 8;
   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_OUT_W-1:0] COUNT_FULL =
      COUNT_OUT_W'((65'd1 << COUNT_BITS) - 65'd1);

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [TS_W-1:0] TS_MAX = '1;
   localparam logic [TS_W-1:0] TS_ONE = 32'h0100_0000;

   localparam int MAX_WAIT      = 17;
   localparam int DRAIN_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 10;
   localparam int RAND_PHASES   = 10;
   localparam int SAT_ITEMS     = 330;
   localparam int PHASE_ITEMS   = 80;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [TS_W-1:0]    time_step;
      logic [GROUP_W-1:0] group_index;
   } hist_item_type;

   typedef struct {
      logic [GROUP_W-1:0]     group;
      logic [COUNT_OUT_W-1:0] count;
   } bin_result_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid       = 1'b0;
   wire                    req_stall;
   logic [OP_W-1:0]        req_op          = '0;
   logic [TS_W-1:0]        req_time_step   = '0;
   logic [GROUP_W-1:0]     req_group_index = '0;

   wire                    rsp_valid;
   logic                   rsp_stall       = 1'b0;
   wire [GROUP_W-1:0]      rsp_group;
   wire [COUNT_OUT_W-1:0]  rsp_count;

   logic                   csr_wr_en       = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index       = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data     = '0;

   // shadow of the histogram state and its registers
   logic [AG_W-1:0]        hist_active;
   logic [TS_W-1:0]        hist_thr    [NUM_THRESHOLDS];
   logic [COUNT_OUT_W-1:0] hist_counts [MAX_GROUPS];
   logic [TS_W-1:0]        next_thr    [NUM_THRESHOLDS];

   hist_item_type  pending_items [$];
   bin_result_type expected_bins [$];

   int unsigned cycle_count   = 0;
   int unsigned mismatches    = 0;
   int unsigned items_taken   = 0;
   int unsigned results_seen  = 0;
   int unsigned full_hits     = 0;
   int unsigned settings_used = 0;
   int unsigned op_seen [4]   = '{0, 0, 0, 0};

   int unsigned req_wait_left = 0;
   int unsigned rsp_wait_left = 0;
   bit          req_burst     = 1'b0;
   bit          rsp_burst     = 1'b0;

   time_step_group_histogram #(
      .MAX_GROUPS (MAX_GROUPS),
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_time_step   (req_time_step),
      .req_group_index (req_group_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_group       (rsp_group),
      .rsp_count       (rsp_count),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always #5 clock = ~clock;

   // zero and out-of-range group settings fold into 1..MAX_GROUPS
   function automatic int groups_used();
      int n;
      n = hist_active;
      if (n < 1) n = 1;
      if (n > MAX_GROUPS) n = MAX_GROUPS;
      return n;
   endfunction

   // histogram update and expected result for one accepted item
   function automatic bin_result_type bin_item(hist_item_type it);
      bin_result_type res;
      int n;
      int g;
      int k;
      res.group = '0;
      res.count = '0;
      case (it.op)
         OP_CLASSIFY: begin
            n = groups_used();
            g = n - 1;
            // first group whose upper bound lies above the time step
            for (k = n - 2; k >= 0; k--) begin
               if (it.time_step < hist_thr[k]) g = k;
            end
            if (hist_counts[g] == COUNT_FULL) full_hits++;
            else hist_counts[g] = hist_counts[g] + 1;
            res.group = g[GROUP_W-1:0];
            res.count = hist_counts[g];
         end
         OP_READ: begin
            res.group = it.group_index;
            if (it.group_index < MAX_GROUPS) res.count = hist_counts[it.group_index];
         end
         OP_CLEAR: begin
            for (k = 0; k < MAX_GROUPS; k++) hist_counts[k] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic int unsigned draw_wait(bit burst);
      if (burst) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   function automatic void push_item(logic [OP_W-1:0] op, logic [TS_W-1:0] ts,
                                     logic [GROUP_W-1:0] gi);
      hist_item_type it;
      it.op          = op;
      it.time_step   = ts;
      it.group_index = gi;
      pending_items.push_back(it);
   endfunction

   // random item, biased toward time steps right at the thresholds
   function automatic hist_item_type random_item(bit classify_only);
      hist_item_type it;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (classify_only || r < 70) it.op = OP_CLASSIFY;
      else if (r < 88)             it.op = OP_READ;
      else if (r < 94)             it.op = OP_CLEAR;
      else                         it.op = OP_UNUSED;
      case ($urandom_range(0, 9))
         0:       it.time_step = '0;
         1:       it.time_step = TS_MAX;
         2, 3, 4, 5:
            it.time_step = hist_thr[$urandom_range(0, NUM_THRESHOLDS - 1)]
                           + TS_W'($urandom_range(0, 2)) - TS_W'(1);
         default: it.time_step = $urandom();
      endcase
      it.group_index = GROUP_W'($urandom_range(0, MAX_GROUPS - 1));
      return it;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_ACTIVE_GROUPS) hist_active = data[AG_W-1:0];
      else hist_thr[idx - CSR_THRESHOLD_1] = data;
   endtask

   // full register set from next_thr plus a group count
   task automatic set_config(input logic [AG_W-1:0] ag);
      int k;
      write_csr(CSR_ACTIVE_GROUPS, CSR_DATA_W'(ag));
      for (k = 0; k < NUM_THRESHOLDS; k++)
         write_csr(CSR_IDX_W'(CSR_THRESHOLD_1 + k), next_thr[k]);
      settings_used++;
   endtask

   // block drained: nothing queued, nothing offered, nothing outstanding
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_bins.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // item driver
   always @(posedge clock) begin : drive_blk
      hist_item_type cur;
      hist_item_type nxt;
      if (reset) begin
         req_valid     <= 1'b0;
         req_wait_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            cur.op          = req_op;
            cur.time_step   = req_time_step;
            cur.group_index = req_group_index;
            expected_bins.push_back(bin_item(cur));
            op_seen[req_op]++;
            items_taken++;
         end
         if ($urandom_range(0, 31) == 0) req_burst <= ~req_burst;
         if (!req_valid || !req_stall) begin
            if (req_wait_left != 0) begin
               req_wait_left <= req_wait_left - 1;
               req_valid     <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt = pending_items.pop_front();
               req_op          <= nxt.op;
               req_time_step   <= nxt.time_step;
               req_group_index <= nxt.group_index;
               req_valid       <= 1'b1;
               req_wait_left   <= draw_wait(req_burst);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin : watch_blk
      bin_result_type want;
      int unsigned n;
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_wait_left <= 0;
      end else begin
         n = (rsp_wait_left != 0) ? rsp_wait_left - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_bins.size() == 0) begin
               if (mismatches < MAX_REPORTS)
                  $display("unexpected item: group %0d count %0d", rsp_group, rsp_count);
               mismatches++;
            end else begin
               want = expected_bins.pop_front();
               if (rsp_group !== want.group || rsp_count !== want.count) begin
                  if (mismatches < MAX_REPORTS)
                     $display("mismatch at item %0d: group %0d/%0d count %0d/%0d (exp/act)",
                              results_seen, want.group, rsp_group, want.count, rsp_count);
                  mismatches++;
               end
            end
            n = draw_wait(rsp_burst);
         end
         if ($urandom_range(0, 31) == 0) rsp_burst <= ~rsp_burst;
         rsp_wait_left <= n;
         rsp_stall     <= (n != 0);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, expected_bins.size());
         $display("time_step_group_histogram regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int k;
      int p;
      int i;
      int n_items;
      logic [32:0] acc;
      logic [AG_W-1:0] ag;
      bit sat_phase;

      hist_active = 1;
      for (k = 0; k < NUM_THRESHOLDS; k++) hist_thr[k] = TS_MAX;
      for (k = 0; k < MAX_GROUPS; k++) hist_counts[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one group, every op, extreme time steps
      push_item(OP_CLASSIFY, '0, '0);
      push_item(OP_CLASSIFY, TS_MAX, 3'd7);
      push_item(OP_READ, TS_MAX, 3'd0);
      push_item(OP_READ, '0, 3'd7);
      push_item(OP_UNUSED, TS_MAX, 3'd7);
      push_item(OP_CLEAR, TS_MAX, 3'd7);
      push_item(OP_READ, '0, 3'd0);
      wait_idle();

      // eight groups on whole-number bounds, probes at the first, fourth and last edges
      for (k = 0; k < NUM_THRESHOLDS; k++) next_thr[k] = TS_ONE * (k + 1);
      set_config(4'd8);
      push_item(OP_CLASSIFY, '0, '0);
      push_item(OP_CLASSIFY, next_thr[0] - 1, '0);
      push_item(OP_CLASSIFY, next_thr[0], '0);
      push_item(OP_CLASSIFY, next_thr[3], '0);
      push_item(OP_CLASSIFY, next_thr[6] - 1, '0);
      push_item(OP_CLASSIFY, next_thr[6], '0);
      push_item(OP_CLASSIFY, TS_MAX, '0);
      for (k = 0; k < MAX_GROUPS; k++) push_item(OP_READ, '0, k[GROUP_W-1:0]);
      wait_idle();

      // zero groups acts as one, fifteen as the maximum
      write_csr(CSR_ACTIVE_GROUPS, '0);
      settings_used++;
      push_item(OP_CLASSIFY, TS_MAX, '0);
      wait_idle();
      write_csr(CSR_ACTIVE_GROUPS, CSR_DATA_W'(4'd15));
      settings_used++;
      push_item(OP_CLASSIFY, TS_MAX, '0);
      push_item(OP_READ, '0, 3'd7);
      wait_idle();

      // random settings; the first phase piles a long classify run into one group
      for (p = 0; p < RAND_PHASES; p++) begin
         sat_phase = (p == 0);
         case ($urandom_range(0, 5))
            0:       ag = 4'd0;
            1:       ag = 4'd1;
            2:       ag = 4'd8;
            3:       ag = AG_W'($urandom_range(9, 15));
            default: ag = AG_W'($urandom_range(2, 8));
         endcase
         if (sat_phase) ag = 4'd1;
         case ($urandom_range(0, 5))
            0: begin
               for (k = 0; k < NUM_THRESHOLDS; k++) next_thr[k] = $urandom();
            end
            1: begin
               for (k = 0; k < NUM_THRESHOLDS; k++) next_thr[k] = (k % 2) ? TS_MAX : '0;
            end
            default: begin
               acc = {1'b0, 32'($urandom_range(0, 32'h0FFF_FFFF))};
               for (k = 0; k < NUM_THRESHOLDS; k++) begin
                  next_thr[k] = acc[32] ? TS_MAX : acc[31:0];
                  acc = acc + ($urandom() >> $urandom_range(2, 8));
               end
            end
         endcase
         set_config(ag);
         n_items = sat_phase ? SAT_ITEMS : PHASE_ITEMS;
         for (i = 0; i < n_items; i++) pending_items.push_back(random_item(sat_phase));
         if (sat_phase) push_item(OP_READ, '0, 3'd0);
         wait_idle();
      end

      $display("covered %0d items under %0d register settings: %0d classify, %0d read,",
               items_taken, settings_used, op_seen[OP_CLASSIFY], op_seen[OP_READ]);
      $display("%0d clear, %0d unused op; %0d results checked, %0d hits on a full counter",
               op_seen[OP_CLEAR], op_seen[OP_UNUSED], results_seen, full_hits);
      if (mismatches == 0 && expected_bins.size() == 0) begin
         $display("time_step_group_histogram regression: pass");
      end else begin
         $display("%0d mismatches, %0d items still expected", mismatches, expected_bins.size());
         $display("time_step_group_histogram regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/tsgh_pkg.sv
rtl/time_step_group_histogram.sv
test/tb_top.sv
